@@ rtl/sts_pkg.sv @@
// ----------------------------------------------------------------------------
// sts_pkg: shared types and constants of the sorted table search block
// Table geometry, action codes, the write-port bundle and the key biasing function.
// ----------------------------------------------------------------------------
package sts_pkg;

   localparam int TABLE_DEPTH    = 1024;
   localparam int ELEMENT_WIDTH  = 32;
   localparam int ADDR_WIDTH     = $clog2(TABLE_DEPTH);
   localparam int COUNT_WIDTH    = $clog2(TABLE_DEPTH + 1);
   localparam int VALUE_WIDTH    = 32;
   localparam int POSITION_WIDTH = 10;
   localparam int ACTION_WIDTH   = 2;

   localparam logic [ACTION_WIDTH-1:0] ACT_CLEAR  = 2'd0;
   localparam logic [ACTION_WIDTH-1:0] ACT_APPEND = 2'd1;
   localparam logic [ACTION_WIDTH-1:0] ACT_SEARCH = 2'd2;

   typedef logic [ELEMENT_WIDTH-1:0] element_type;
   typedef logic [ADDR_WIDTH-1:0]    addr_type;
   typedef logic [COUNT_WIDTH-1:0]   count_type;

   typedef struct packed {
      logic        en;
      addr_type    addr;
      element_type data;
   } wr_port_type;

   // Sign-extend or truncate to the element width, then flip the sign bit so
   // an unsigned compare gives signed order.
   function automatic element_type to_biased(input logic signed [VALUE_WIDTH-1:0] v);
      logic signed [127:0] ext;
      element_type         sign_bit;
      ext      = 128'(v);
      sign_bit = element_type'(1) << (ELEMENT_WIDTH - 1);
      return ext[ELEMENT_WIDTH-1:0] ^ sign_bit;
   endfunction

endpackage

@@ rtl/sorted_table_binary_search.sv @@
// ----------------------------------------------------------------------------
// sorted_table_binary_search: table of signed words with binary search
// The loader must append ascending words, unchecked; search probes valid entries.
// ----------------------------------------------------------------------------
// Usage: drive req_action/req_value and raise start while busy is low; that
// edge takes the transaction. Every transaction gives exactly one result,
// shown for one cycle with rsp_valid high; the receiver cannot stall it, so
// capture it on that cycle. Clear and append finish at once: the result
// appears the cycle after acceptance and busy stays low, so a new
// transaction may follow every cycle. A search holds busy high while it
// probes the table, with at most log2(TABLE_DEPTH) + 1 probes; each probe
// issues the read on the table's single read port (ST_PROBE), then compares
// the registered word (ST_CMP); a miss ends in an ST_PROBE that sees the
// empty interval. Appends to a full table are dropped and flagged with
// rsp_full_error. Entries are never cleared; a clear only resets the entry
// count.
// ----------------------------------------------------------------------------
module sorted_table_binary_search (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [sts_pkg::ACTION_WIDTH-1:0]       req_action,
   input  logic signed [sts_pkg::VALUE_WIDTH-1:0] req_value,
   output logic                                   rsp_valid,
   output logic                                   rsp_found,
   output logic [sts_pkg::POSITION_WIDTH-1:0]     rsp_position,
   output logic                                   rsp_full_error
);
   import sts_pkg::*;

   // sequencer states
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_PROBE = 2'd1;   // interval check, issue read
   localparam logic [1:0] ST_CMP   = 2'd2;   // compare returned word

   logic [1:0]  state_ff, state_in;
   count_type   count_ff, count_in;
   count_type   lower_ff, lower_in;
   count_type   upper_ff, upper_in;
   count_type   middle_ff, middle_in;
   element_type key_ff, key_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_found_ff, rsp_found_in;
   logic [POSITION_WIDTH-1:0] rsp_position_ff, rsp_position_in;
   logic                      rsp_full_error_ff, rsp_full_error_in;

   wr_port_type wr;
   logic        rd_en;
   element_type rd_data;
   logic        accept;
   element_type req_word;
   count_type   middle_calc;
   logic [31:0] middle_wide;

   sts_table u_table (
      .clock   (clock),
      .wr      (wr),
      .rd_en   (rd_en),
      .rd_addr (middle_calc[ADDR_WIDTH-1:0]),
      .rd_data (rd_data)
   );

   assign busy        = (state_ff != ST_IDLE);
   assign accept      = start && !busy;
   assign req_word    = to_biased(req_value);
   // midpoint of [lower, upper); the interval stays inside the table
   assign middle_calc = lower_ff + ((upper_ff - lower_ff) >> 1);
   assign middle_wide = 32'(middle_ff);

   always_comb begin
      state_in          = state_ff;
      count_in          = count_ff;
      lower_in          = lower_ff;
      upper_in          = upper_ff;
      middle_in         = middle_ff;
      key_in            = key_ff;
      rsp_valid_in      = 1'b0;
      rsp_found_in      = rsp_found_ff;
      rsp_position_in   = rsp_position_ff;
      rsp_full_error_in = rsp_full_error_ff;
      wr.en             = 1'b0;
      wr.addr           = count_ff[ADDR_WIDTH-1:0];
      wr.data           = req_word;
      rd_en             = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_found_in      = 1'b0;
               rsp_position_in   = '0;
               rsp_full_error_in = 1'b0;
               case (req_action)
                  ACT_CLEAR: begin
                     count_in     = '0;
                     rsp_valid_in = 1'b1;
                  end
                  ACT_APPEND: begin
                     if (count_ff < count_type'(TABLE_DEPTH)) begin
                        wr.en    = 1'b1;
                        count_in = count_ff + count_type'(1);
                     end else begin
                        rsp_full_error_in = 1'b1;
                     end
                     rsp_valid_in = 1'b1;
                  end
                  ACT_SEARCH: begin
                     lower_in = '0;
                     upper_in = count_ff;
                     key_in   = req_word;
                     state_in = ST_PROBE;
                  end
                  default: begin
                     // unused code: no state change, all-zero result
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_PROBE: begin
            if (lower_ff < upper_ff) begin
               rd_en     = 1'b1;
               middle_in = middle_calc;
               state_in  = ST_CMP;
            end else begin
               // empty interval: miss
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_CMP: begin
            if (rd_data == key_ff) begin
               rsp_found_in    = 1'b1;
               rsp_position_in = middle_wide[POSITION_WIDTH-1:0];
               rsp_valid_in    = 1'b1;
               state_in        = ST_IDLE;
            end else if (rd_data < key_ff) begin
               lower_in = middle_ff + count_type'(1);
               state_in = ST_PROBE;
            end else begin
               upper_in = middle_ff;
               state_in = ST_PROBE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lower_ff          <= lower_in;
      upper_ff          <= upper_in;
      middle_ff         <= middle_in;
      key_ff            <= key_in;
      rsp_found_ff      <= rsp_found_in;
      rsp_position_ff   <= rsp_position_in;
      rsp_full_error_ff <= rsp_full_error_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_position   = rsp_position_ff;
   assign rsp_full_error = rsp_full_error_ff;

endmodule

@@ rtl/sts_table.sv @@
// ----------------------------------------------------------------------------
// sts_table: element storage
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module sts_table (
   input  logic                clock,
   input  sts_pkg::wr_port_type wr,
   input  logic                rd_en,
   input  sts_pkg::addr_type   rd_addr,
   output sts_pkg::element_type rd_data
);
   import sts_pkg::*;

   element_type mem [TABLE_DEPTH];
   element_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ bench/sts_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_checker: result checker for the sorted table binary search block
// Watches the request and result channels, keeps its own copy of the table,
// predicts one result per accepted transaction and compares it in order.
// ----------------------------------------------------------------------------
module sts_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic                                   busy,
   input  logic [sts_pkg::ACTION_WIDTH-1:0]       req_action,
   input  logic signed [sts_pkg::VALUE_WIDTH-1:0] req_value,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_found,
   input  logic [sts_pkg::POSITION_WIDTH-1:0]     rsp_position,
   input  logic                                   rsp_full_error,
   output int                                     mismatches,
   output int                                     pending
);
   import sts_pkg::*;

   localparam int PRINT_CAP = 100;

   typedef logic signed [ELEMENT_WIDTH-1:0] word_type;

   typedef struct packed {
      logic                      found;
      logic [POSITION_WIDTH-1:0] position;
      logic                      full_error;
   } outcome_type;

   word_type    stored_words [TABLE_DEPTH];
   int unsigned word_count;
   outcome_type predicted_outcomes [$];
   outcome_type oldest;
   int          retired;

   initial begin
      mismatches = 0;
      pending    = 0;
      word_count = 0;
      retired    = 0;
   end

   // one line per mismatch; printing stops after a cap, counting does not
   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= PRINT_CAP)
         $display("[%0t] mismatch on transaction %0d: %s", $time, retired, what);
   endtask

   // key as the block sees it: sign-extended, then cut to the element width
   function automatic word_type as_element(input logic signed [VALUE_WIDTH-1:0] v);
      logic signed [63:0] wide;
      wide = v;
      return wide[ELEMENT_WIDTH-1:0];
   endfunction

   // applies one transaction to the table copy and returns its result
   function automatic outcome_type predict_outcome(
         input logic [ACTION_WIDTH-1:0]       act,
         input logic signed [VALUE_WIDTH-1:0] val);
      outcome_type res;
      word_type    key;
      int unsigned lower, upper, middle;
      bit          hit;
      res = '0;
      key = as_element(val);
      case (act)
         ACT_CLEAR: begin
            word_count = 0;
         end
         ACT_APPEND: begin
            if (word_count < TABLE_DEPTH) begin
               stored_words[word_count] = key;
               word_count++;
            end else begin
               res.full_error = 1'b1;
            end
         end
         ACT_SEARCH: begin
            lower = 0;
            upper = word_count;
            hit   = 1'b0;
            while (!hit && lower < upper) begin
               middle = lower + (upper - lower) / 2;
               if (stored_words[middle] == key) begin
                  hit          = 1'b1;
                  res.found    = 1'b1;
                  res.position = POSITION_WIDTH'(middle);
               end else if (stored_words[middle] < key) begin
                  lower = middle + 1;
               end else begin
                  upper = middle;
               end
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         predicted_outcomes.delete();
         word_count = 0;
      end else begin
         if (rsp_valid === 1'b1) begin
            if (predicted_outcomes.size() == 0) begin
               report_mismatch("result with no transaction outstanding");
            end else begin
               oldest = predicted_outcomes.pop_front();
               if (rsp_found !== oldest.found)
                  report_mismatch($sformatf("found %b, predicted %b",
                                            rsp_found, oldest.found));
               if (rsp_position !== oldest.position)
                  report_mismatch($sformatf("position %0d, predicted %0d",
                                            rsp_position, oldest.position));
               if (rsp_full_error !== oldest.full_error)
                  report_mismatch($sformatf("full_error %b, predicted %b",
                                            rsp_full_error, oldest.full_error));
            end
            retired++;
         end
         if (start === 1'b1 && busy === 1'b0) begin
            predicted_outcomes = {predicted_outcomes,
                                  predict_outcome(req_action, req_value)};
         end
      end
      pending = predicted_outcomes.size();
   end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top of the sorted table binary search block
// Drives clear, append and search transactions with random gaps; a checker
// beside the block predicts and compares every result. Directed corners
// first, then random load-and-search rounds and one pass that fills the table.
// ----------------------------------------------------------------------------
module tb;
   import sts_pkg::*;

   // action code the block does not use; it must change nothing
   localparam logic [ACTION_WIDTH-1:0] ACT_UNUSED = 2'd3;

   localparam int ITEM_TARGET  = 1550;   // stimulus stops near this count
   localparam int FILL_AFTER   = 250;    // the full-table pass starts here
   localparam int CYCLE_LIMIT  = 500000; // slowest legal run is far below
   localparam int DRAIN_CYCLES = 30;     // longer than the longest search

   localparam logic signed [VALUE_WIDTH-1:0] WORD_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_WIDTH-1:0] WORD_MAX = 32'sh7fff_ffff;
   localparam longint                        LONG_MIN = -64'sd2147483648;
   localparam longint                        LONG_MAX = 64'sd2147483647;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            start      = 1'b0;
   logic                            busy;
   logic [ACTION_WIDTH-1:0]         req_action = ACT_CLEAR;
   logic signed [VALUE_WIDTH-1:0]   req_value  = '0;
   logic                            rsp_valid;
   logic                            rsp_found;
   logic [POSITION_WIDTH-1:0]       rsp_position;
   logic                            rsp_full_error;

   int mismatches;
   int pending;
   int sent   = 0;   // counted transactions, unused action code excluded
   int cycles = 0;
   bit steady = 1'b0; // when set, transactions go back to back

   // values appended in the current round, used to aim search keys
   logic signed [VALUE_WIDTH-1:0] loaded [$];

   always #5 clock = ~clock;

   sorted_table_binary_search dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_found      (rsp_found),
      .rsp_position   (rsp_position),
      .rsp_full_error (rsp_full_error)
   );

   sts_checker result_check (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_found      (rsp_found),
      .rsp_position   (rsp_position),
      .rsp_full_error (rsp_full_error),
      .mismatches     (mismatches),
      .pending        (pending)
   );

   // Watchdog: a hung handshake or a lost result ends up here.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Idle time before a transaction: mostly none, some short, a few long.
   // Long gaps can outlast a search, short ones can land inside its probe loop.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      else if (r < 92)
         return $urandom_range(1, 4);
      else
         return $urandom_range(10, 40);
   endfunction

   // Sends one transaction and returns at the edge that takes it.
   // Called at a rising edge; start is only ever assigned once per edge.
   task automatic issue(input logic [ACTION_WIDTH-1:0]       act,
                        input logic signed [VALUE_WIDTH-1:0] val);
      int gap;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         // idle: start low, junk on the payload the block must ignore
         start      <= 1'b0;
         req_action <= ACTION_WIDTH'($urandom_range(0, 3));
         req_value  <= $urandom;
         repeat (gap) @(posedge clock);
      end
      req_action <= act;
      req_value  <= val;
      start      <= 1'b1;
      // busy is sampled before the edge updates it: low here means taken
      do @(posedge clock); while (busy !== 1'b0);
      if (act != ACT_UNUSED)
         sent++;
   endtask

   // Search key: mostly a loaded word (hit) or its neighbor (likely miss),
   // sometimes anything, sometimes the extremes of the range.
   function automatic logic signed [VALUE_WIDTH-1:0] pick_key();
      int                            r;
      logic signed [VALUE_WIDTH-1:0] k;
      r = $urandom_range(0, 9);
      if (r == 9) begin
         k = $urandom_range(0, 1) ? WORD_MAX : WORD_MIN;
      end else if (loaded.size() == 0 || r == 8) begin
         k = $urandom;
      end else begin
         k = loaded[$urandom_range(0, loaded.size() - 1)];
         if (r == 5)
            k = k - 1;
         else if (r >= 6)
            k = k + 1;
      end
      return k;
   endfunction

   // Step between neighbors of an ascending load: tight spans give
   // duplicates, wide ones sweep the sign and the high bits.
   function automatic longint pick_span();
      case ($urandom_range(0, 3))
         0:       return 2;
         1:       return 1000;
         2:       return 64'd1 << 24;
         default: return 64'd1 << 28;
      endcase
   endfunction

   // One round: clear, load a table, search it. Most rounds load ascending
   // words; some load unsorted words, some are pure noise.
   task automatic small_round();
      int     kind, n;
      longint cur, span;
      steady = ($urandom_range(0, 4) == 0);
      kind   = $urandom_range(0, 9);
      n      = ($urandom_range(0, 5) == 0) ? $urandom_range(31, 90) : $urandom_range(0, 30);
      loaded.delete();
      if (kind == 9) begin
         // noise: any action, any value, the unused code included
         repeat (n + 4) issue(ACTION_WIDTH'($urandom_range(0, 3)), $urandom);
      end else begin
         issue(ACT_CLEAR, $urandom);
         span = pick_span();
         cur  = ($urandom_range(0, 7) == 0) ? LONG_MIN : longint'(int'($urandom));
         for (int i = 0; i < n; i++) begin
            if (kind == 8)
               cur = longint'(int'($urandom));   // unsorted load
            else if (i > 0)
               cur += $urandom_range(0, int'(span));
            if (cur > LONG_MAX)
               cur = LONG_MAX;
            loaded = {loaded, cur[31:0]};
            issue(ACT_APPEND, cur[31:0]);
         end
         repeat ($urandom_range(2, 12)) issue(ACT_SEARCH, pick_key());
      end
   endtask

   // Fills all TABLE_DEPTH entries in ascending order across the whole
   // range, then pushes appends into the full table and runs deep searches.
   task automatic fill_round();
      longint cur;
      loaded.delete();
      steady = 1'b0;
      issue(ACT_CLEAR, $urandom);
      cur = LONG_MIN + $urandom_range(0, 1000);
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (i % 128 == 0)
            steady = ($urandom_range(0, 2) == 0);
         loaded = {loaded, cur[31:0]};
         issue(ACT_APPEND, cur[31:0]);
         cur += $urandom_range(0, (1 << 22) - 1);
         if (cur > LONG_MAX)
            cur = LONG_MAX;
      end
      steady = 1'b0;
      repeat (4) issue(ACT_APPEND, $urandom);   // refused: table full
      repeat (40) issue(ACT_SEARCH, pick_key());
      issue(ACT_APPEND, WORD_MAX);              // still refused
      issue(ACT_SEARCH, WORD_MAX);
      issue(ACT_SEARCH, WORD_MIN);
   endtask

   initial begin
      // reset held from time zero, then released once
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // --- directed corners ---
      // search in an empty table, and the unused action code
      issue(ACT_SEARCH, '0);
      issue(ACT_SEARCH, WORD_MIN);
      issue(ACT_UNUSED, '1);
      // extremes of the range, a duplicate pair around zero
      issue(ACT_APPEND, WORD_MIN);
      issue(ACT_APPEND, -32'sd1);
      issue(ACT_APPEND, '0);
      issue(ACT_APPEND, '0);
      issue(ACT_APPEND, 32'sd1);
      issue(ACT_APPEND, WORD_MAX);
      // hits at both ends, on the duplicate, and misses between words
      issue(ACT_SEARCH, WORD_MIN);
      issue(ACT_SEARCH, WORD_MAX);
      issue(ACT_SEARCH, '0);
      issue(ACT_SEARCH, -32'sd1);
      issue(ACT_SEARCH, 32'sd1);
      issue(ACT_SEARCH, 32'sd5);
      issue(ACT_SEARCH, -32'sd5);
      // break the order: a small word after the largest one
      issue(ACT_APPEND, 32'sd7);
      issue(ACT_SEARCH, 32'sd7);
      issue(ACT_SEARCH, WORD_MAX);
      // clear keeps the words but empties the table
      issue(ACT_CLEAR, $urandom);
      issue(ACT_SEARCH, WORD_MIN);

      // --- random rounds, with the full-table pass in between ---
      while (sent < FILL_AFTER)
         small_round();
      fill_round();
      while (sent < ITEM_TARGET)
         small_round();

      start <= 1'b0;
      // let the last transaction show up in the pending count first
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && pending == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
